/* rtl/pcmm_pkg.sv */
// Shared types, constants and codes for the PC memory map decoder.
`default_nettype none

package pcmm_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ADDR_W-1:0] BIOS_ROM_BYTES = 32'd524288;
  localparam logic [ADDR_W-1:0] EXP_ROM_BYTES = 32'd131072;
  localparam logic [ADDR_W-1:0] BIOS_OFS_MASK = BIOS_ROM_BYTES - 32'd1;
  localparam logic [ADDR_W-1:0] EXP_MASK = EXP_ROM_BYTES - 32'd1;
  localparam logic [ADDR_W-1:0] BIOS_BASE = ~BIOS_OFS_MASK;

  localparam logic [ADDR_W-1:0] SEG128_MASK = 32'hfffe_0000;
  localparam logic [ADDR_W-1:0] SHADOW_MASK = 32'hfffc_0000;
  localparam logic [ADDR_W-1:0] VGA_BASE = 32'h000a_0000;
  localparam logic [ADDR_W-1:0] SHADOW_BASE = 32'h000c_0000;
  localparam logic [ADDR_W-1:0] BIOS_SEG_BASE = 32'h000e_0000;
  localparam logic [ADDR_W-1:0] PAGE_OFS_MASK = 32'h0000_0fff;
  localparam logic [ADDR_W-1:0] PAGE_MASK = ~PAGE_OFS_MASK;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PCI_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMRAM_AVAIL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMRAM_OPEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_APIC_PAGE = 3'd4;

  localparam logic [ADDR_W-1:0] RAM_SIZE_RST = 32'h0200_0000;
  localparam logic [ADDR_W-1:0] APIC_PAGE_RST = 32'hfee0_0000;

  // PCI shadow memtypes
  localparam logic [1:0] MT_ROM = 2'd0;
  localparam logic [1:0] MT_RAM = 2'd1;

  typedef enum logic [1:0] {
    TGT_VETO  = 2'd0,
    TGT_RAM   = 2'd1,
    TGT_ROM   = 2'd2,
    TGT_DUMMY = 2'd3
  } pcmm_tgt_t;

  typedef struct packed {
    logic [ADDR_W-1:0] ram_size;
    logic              pci_enable;
    logic              smram_avail;
    logic              smram_open;
    logic [ADDR_W-1:0] apic_page;
  } pcmm_cfg_t;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] phys_addr;
    logic              code_fetch;
    logic              in_smm;
    logic [1:0]        shadow_type;
    logic              handler_hit;
    logic              monitor_hit;
  } pcmm_req_t;

  typedef struct packed {
    pcmm_tgt_t         target;
    logic [ADDR_W-1:0] offset;
    logic              bad_type;
    logic              stamp_write;
  } pcmm_res_t;

endpackage

`default_nettype wire

/* rtl/pc_memory_map_decode_core.sv */
// Top level of the PC memory map decoder: input register, decode, result register.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | func, phys_addr, code_fetch, in_smm,
//          |           |                       | shadow_type, handler_hit, monitor_hit
//  out_    | output    | out_valid / out_stall | target, offset, bad_type, stamp_write
//  cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item passes the input register
// and then the result register, which drives out_valid.
// The path between the input register and the result register holds the whole decode:
// one 32-bit compare against ram_size, the APIC page compare and one 32-bit add.
// rst_n (synchronous) empties both stages and loads the register reset values.
// in_stall rises only when both stages hold items and out_stall is high.
`default_nettype none

module pc_memory_map_decode_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_func,
  input  wire logic [31:0]                      in_phys_addr,
  input  wire logic                             in_code_fetch,
  input  wire logic                             in_in_smm,
  input  wire logic [1:0]                       in_shadow_type,
  input  wire logic                             in_handler_hit,
  input  wire logic                             in_monitor_hit,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_target,
  output logic [31:0]                           out_offset,
  output logic                                  out_bad_type,
  output logic                                  out_stamp_write,
  input  wire logic                             cfg_we,
  input  wire logic [pcmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pcmm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcmm_pkg::*;

  pcmm_cfg_t cfg;
  pcmm_req_t req_r;
  pcmm_res_t res_r;
  pcmm_res_t dec_res;
  logic      req_vld_r;
  logic      res_vld_r;
  logic      res_take;
  logic      req_take;

  pcmm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  pcmm_decode u_decode (
    .cfg_i (cfg),
    .req_i (req_r),
    .res_o (dec_res)
  );

  // result stage can load when empty or its item leaves this cycle
  assign res_take = !res_vld_r || !out_stall;
  assign req_take = !req_vld_r || res_take;
  assign in_stall = !req_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (req_take) begin
        req_vld_r <= in_valid;
      end
      if (res_take) begin
        res_vld_r <= req_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take && in_valid) begin
      req_r.func        <= in_func;
      req_r.phys_addr   <= in_phys_addr;
      req_r.code_fetch  <= in_code_fetch;
      req_r.in_smm      <= in_in_smm;
      req_r.shadow_type <= in_shadow_type;
      req_r.handler_hit <= in_handler_hit;
      req_r.monitor_hit <= in_monitor_hit;
    end
    if (res_take && req_vld_r) begin
      res_r <= dec_res;
    end
  end

  assign out_valid       = res_vld_r;
  assign out_target      = res_r.target;
  assign out_offset      = res_r.offset;
  assign out_bad_type    = res_r.bad_type;
  assign out_stamp_write = res_r.stamp_write;

  a_veto_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.target == TGT_VETO) |-> (res_r.offset == '0 && !res_r.stamp_write))
    else $error("vetoed item carries offset or stamp");

  a_stamp_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.stamp_write) |-> (res_r.target == TGT_RAM))
    else $error("write stamp on a non-RAM item");

  a_bad_veto: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.bad_type) |-> (res_r.target == TGT_VETO))
    else $error("bad memtype item not vetoed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (req_vld_r && res_vld_r && out_stall))
    else $error("input stalled with room in the pipe");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && out_stall) |=> (res_vld_r && $stable(res_r)))
    else $error("stalled result lost or changed");

endmodule

`default_nettype wire

/* rtl/pcmm_cfg.sv */
// Configuration register file of the memory map decoder.
`default_nettype none

module pcmm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [pcmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pcmm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pcmm_pkg::pcmm_cfg_t                   cfg_o
);
  import pcmm_pkg::*;

  pcmm_cfg_t cfg_r;
  pcmm_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAM_SIZE:    cfg_nxt.ram_size = cfg_data[ADDR_W-1:0];
        CFG_PCI_ENABLE:  cfg_nxt.pci_enable = cfg_data[0];
        CFG_SMRAM_AVAIL: cfg_nxt.smram_avail = cfg_data[0];
        CFG_SMRAM_OPEN:  cfg_nxt.smram_open = cfg_data[0];
        CFG_APIC_PAGE:   cfg_nxt.apic_page = cfg_data[ADDR_W-1:0];
        default:         cfg_nxt = cfg_r; // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ram_size    <= RAM_SIZE_RST;
      cfg_r.pci_enable  <= 1'b0;
      cfg_r.smram_avail <= 1'b0;
      cfg_r.smram_open  <= 1'b0;
      cfg_r.apic_page   <= APIC_PAGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

/* rtl/pcmm_decode.sv */
// Combinational decode of one access into target store and offset.
`default_nettype none

module pcmm_decode (
  input  pcmm_pkg::pcmm_cfg_t cfg_i,
  input  pcmm_pkg::pcmm_req_t req_i,
  output pcmm_pkg::pcmm_res_t res_o
);
  import pcmm_pkg::*;

  logic [ADDR_W-1:0] a;
  logic              vga;
  logic              shadow;
  logic              below_ram;
  logic              in_bios;
  logic              apic_hit;
  logic              smram_fetch;
  logic [ADDR_W-1:0] rom_ofs;
  pcmm_res_t         veto;

  assign a           = req_i.phys_addr;
  assign vga         = (a & SEG128_MASK) == VGA_BASE;
  assign shadow      = (a & SHADOW_MASK) == SHADOW_BASE;
  assign below_ram   = a < cfg_i.ram_size;
  assign in_bios     = a >= BIOS_BASE;
  assign apic_hit    = (a & PAGE_MASK) == cfg_i.apic_page;
  assign smram_fetch = req_i.code_fetch && vga && cfg_i.smram_avail &&
                       (cfg_i.smram_open || req_i.in_smm);
  // BIOS segment maps to the low ROM part, the rest to the expansion part
  assign rom_ofs     = ((a & SEG128_MASK) == BIOS_SEG_BASE) ? (a & BIOS_OFS_MASK)
                                                            : ((a & EXP_MASK) + BIOS_ROM_BYTES);

  assign veto = '{target: TGT_VETO, offset: '0, bad_type: 1'b0, stamp_write: 1'b0};

  always_comb begin
    res_o = veto;
    priority if (apic_hit) begin
      res_o = veto;
    end else if (smram_fetch) begin
      res_o.target = TGT_RAM;
      res_o.offset = a;
    end else if ((req_i.monitor_hit && req_i.func) || req_i.handler_hit) begin
      res_o = veto;
    end else if (!req_i.func) begin
      priority if (vga) begin
        res_o = veto;
      end else if (cfg_i.pci_enable && shadow) begin
        unique case (req_i.shadow_type)
          MT_ROM: begin
            res_o.target = TGT_ROM;
            res_o.offset = rom_ofs;
          end
          MT_RAM: begin
            res_o.target = TGT_RAM;
            res_o.offset = a;
          end
          default: res_o.bad_type = 1'b1;
        endcase
      end else if (below_ram) begin
        res_o.target = shadow ? TGT_ROM : TGT_RAM;
        res_o.offset = shadow ? rom_ofs : a;
      end else if (in_bios) begin
        res_o.target = TGT_ROM;
        res_o.offset = a & BIOS_OFS_MASK;
      end else begin
        res_o.target = TGT_DUMMY;
        res_o.offset = a & PAGE_OFS_MASK;
      end
    end else if (below_ram && !vga && !in_bios && !shadow) begin
      res_o.target      = TGT_RAM;
      res_o.offset      = a;
      res_o.stamp_write = 1'b1;
    end else begin
      res_o = veto;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/pc_memory_map_decode_core_tb.sv */
// Self-checking testbench for the PC memory map decoder: directed table plus random accesses.
module pc_memory_map_decode_core_tb;
  import pcmm_pkg::*;

  localparam bit RD = 1'b0;
  localparam bit WR = 1'b1;
  localparam logic [1:0] MT_BAD2 = 2'd2;
  localparam logic [1:0] MT_BAD3 = 2'd3;
  localparam logic [31:0] ROM_BIOS_SPAN = 32'd524288;
  localparam logic [31:0] ROM_EXP_SPAN = 32'd131072;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 110;

  typedef struct {
    pcmm_req_t acc;
    bit        typed;
    pcmm_res_t res;
  } probe_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [31:0] in_phys_addr = '0;
  logic in_code_fetch = 1'b0;
  logic in_in_smm = 1'b0;
  logic [1:0] in_shadow_type = '0;
  logic in_handler_hit = 1'b0;
  logic in_monitor_hit = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_target;
  logic [31:0] out_offset;
  logic out_bad_type;
  logic out_stamp_write;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pcmm_cfg_t map_cfg = '{ram_size: 32'h0200_0000, pci_enable: 1'b0, smram_avail: 1'b0,
                         smram_open: 1'b0, apic_page: 32'hfee0_0000};
  pcmm_res_t pending_decodes[$];
  probe_t probes[$];
  bit quiet = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  pc_memory_map_decode_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_phys_addr(in_phys_addr), .in_code_fetch(in_code_fetch),
    .in_in_smm(in_in_smm), .in_shadow_type(in_shadow_type),
    .in_handler_hit(in_handler_hit), .in_monitor_hit(in_monitor_hit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_target(out_target), .out_offset(out_offset),
    .out_bad_type(out_bad_type), .out_stamp_write(out_stamp_write),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rom_ofs(logic [31:0] a);
    if ((a & 32'hfffe_0000) == 32'h000e_0000) return a & (ROM_BIOS_SPAN - 32'd1);
    return (a & (ROM_EXP_SPAN - 32'd1)) + ROM_BIOS_SPAN;
  endfunction

  function automatic pcmm_res_t decode_access(pcmm_req_t r);
    pcmm_res_t d;
    logic [31:0] a;
    logic vga, shadow;
    d = '0;
    d.target = TGT_VETO;
    a = r.phys_addr;
    vga = (a & 32'hfffe_0000) == 32'h000a_0000;
    shadow = (a & 32'hfffc_0000) == 32'h000c_0000;
    if ((a & ~32'h0000_0fff) == map_cfg.apic_page) return d;
    // SMRAM fetch goes to RAM even for a write, without touching the stamp
    if (r.code_fetch && vga && map_cfg.smram_avail && (map_cfg.smram_open || r.in_smm)) begin
      d.target = TGT_RAM;
      d.offset = a;
      return d;
    end
    if ((r.monitor_hit && r.func) || r.handler_hit) return d;
    if (!r.func) begin
      if (vga) begin
        d.target = TGT_VETO;
      end else if (map_cfg.pci_enable && shadow) begin
        case (r.shadow_type)
          MT_ROM: begin
            d.target = TGT_ROM;
            d.offset = rom_ofs(a);
          end
          MT_RAM: begin
            d.target = TGT_RAM;
            d.offset = a;
          end
          default: d.bad_type = 1'b1;
        endcase
      end else if (a < map_cfg.ram_size) begin
        d.target = shadow ? TGT_ROM : TGT_RAM;
        d.offset = shadow ? rom_ofs(a) : a;
      end else if (a >= ~(ROM_BIOS_SPAN - 32'd1)) begin
        d.target = TGT_ROM;
        d.offset = a & (ROM_BIOS_SPAN - 32'd1);
      end else begin
        d.target = TGT_DUMMY;
        d.offset = a & 32'h0000_0fff;
      end
    end else if (!(a >= map_cfg.ram_size || vga || a >= ~(ROM_BIOS_SPAN - 32'd1) || shadow))
    begin
      d.target = TGT_RAM;
      d.offset = a;
      d.stamp_write = 1'b1;
    end
    return d;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic pcmm_req_t random_access();
    pcmm_req_t r;
    logic [31:0] a;
    r.func = 1'($urandom_range(0, 1));
    r.code_fetch = ($urandom_range(0, 2) == 0);
    r.in_smm = 1'($urandom_range(0, 1));
    r.shadow_type = 2'($urandom_range(0, 3));
    r.handler_hit = ($urandom_range(0, 9) == 0);
    r.monitor_hit = ($urandom_range(0, 6) == 0);
    a = $urandom();
    case ($urandom_range(0, 8))
      0: a = {map_cfg.apic_page[31:12], a[11:0]};
      1: a = 32'h000a_0000 | (a & 32'h0001_ffff);
      2, 3: a = 32'h000c_0000 | (a & 32'h0003_ffff);
      4: a = map_cfg.ram_size + (a & 32'h0000_000f) - 32'd8;
      5: a = {13'h1fff, a[18:0]};
      6: a = 32'hfff8_0000 + {{24{a[7]}}, a[7:0]};
      7: if (map_cfg.ram_size != 0) a = a % map_cfg.ram_size;
      default: ;
    endcase
    r.phys_addr = a;
    return r;
  endfunction

  function automatic void add_probe(bit fn, logic [31:0] a, bit fe, bit sm, logic [1:0] st,
                                    bit hd, bit mo, bit typed, pcmm_tgt_t tg,
                                    logic [31:0] of, bit bd, bit sw);
    probe_t p;
    p.acc.func = fn;
    p.acc.phys_addr = a;
    p.acc.code_fetch = fe;
    p.acc.in_smm = sm;
    p.acc.shadow_type = st;
    p.acc.handler_hit = hd;
    p.acc.monitor_hit = mo;
    p.typed = typed;
    p.res.target = tg;
    p.res.offset = of;
    p.res.bad_type = bd;
    p.res.stamp_write = sw;
    probes.push_back(p);
  endfunction

  task automatic send_access(input pcmm_req_t acc, input bit typed, input pcmm_res_t res);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= acc.func;
    in_phys_addr <= acc.phys_addr;
    in_code_fetch <= acc.code_fetch;
    in_in_smm <= acc.in_smm;
    in_shadow_type <= acc.shadow_type;
    in_handler_hit <= acc.handler_hit;
    in_monitor_hit <= acc.monitor_hit;
    do @(posedge clk); while (in_stall);
    pending_decodes.push_back(typed ? res : decode_access(acc));
  endtask

  task automatic walk_probes();
    foreach (probes[i]) send_access(probes[i].acc, probes[i].typed, probes[i].res);
    probes.delete();
  endtask

  // Drop valid and wait until every decode has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_decodes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      CFG_RAM_SIZE: map_cfg.ram_size = d;
      CFG_PCI_ENABLE: map_cfg.pci_enable = d[0];
      CFG_SMRAM_AVAIL: map_cfg.smram_avail = d[0];
      CFG_SMRAM_OPEN: map_cfg.smram_open = d[0];
      CFG_APIC_PAGE: map_cfg.apic_page = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin : stall_gen
    int n;
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      n = gap_len();
      out_stall <= (n != 0);
      stall_left <= (n != 0) ? n - 1 : 0;
    end
  end

  always @(posedge clk) begin : result_check
    pcmm_res_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: target %0d offset %h", out_target, out_offset);
      end else begin
        exp = pending_decodes.pop_front();
        if (out_target !== exp.target || out_offset !== exp.offset ||
            out_bad_type !== exp.bad_type || out_stamp_write !== exp.stamp_write) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp/act: target %0d/%0d offset %h/%h bad %0d/%0d stamp %0d/%0d",
                     exp.target, out_target, exp.offset, out_offset,
                     exp.bad_type, out_bad_type, exp.stamp_write, out_stamp_write);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("[pc_memory_map_decode_core] ERROR");
    $finish;
  end

  initial begin : run
    int hold_at;
    logic [31:0] ram, apic;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: 32 MiB RAM, no PCI decode, no SMRAM, APIC at 0xFEE00000
    add_probe(RD, 32'h0000_0000, 0, 0, MT_ROM, 0, 0, 1, TGT_RAM, 32'h0000_0000, 0, 0);
    add_probe(WR, 32'h0000_1234, 0, 0, MT_ROM, 0, 0, 1, TGT_RAM, 32'h0000_1234, 0, 1);
    add_probe(RD, 32'hffff_ffff, 1, 1, MT_BAD3, 0, 0, 1, TGT_ROM, 32'h0007_ffff, 0, 0);
    add_probe(WR, 32'hffff_ffff, 0, 0, MT_ROM, 0, 0, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(RD, 32'hfee0_0010, 0, 0, MT_ROM, 0, 0, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(WR, 32'hfee0_0fff, 0, 0, MT_ROM, 0, 0, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(RD, 32'h000a_0000, 0, 0, MT_ROM, 0, 0, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(RD, 32'h000c_0000, 0, 0, MT_BAD2, 0, 0, 0, TGT_VETO, 32'h0, 0, 0);
    add_probe(RD, 32'h000e_1234, 0, 0, MT_ROM, 0, 0, 0, TGT_VETO, 32'h0, 0, 0);
    add_probe(RD, 32'h1000_0abc, 0, 0, MT_ROM, 0, 0, 1, TGT_DUMMY, 32'h0000_0abc, 0, 0);
    add_probe(WR, 32'h1000_0000, 0, 0, MT_ROM, 0, 0, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(RD, 32'h0000_2000, 0, 0, MT_ROM, 1, 0, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(RD, 32'h0000_5000, 0, 0, MT_ROM, 0, 1, 1, TGT_RAM, 32'h0000_5000, 0, 0);
    add_probe(WR, 32'h0000_5000, 0, 0, MT_ROM, 0, 1, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(WR, 32'h01ff_ffff, 0, 0, MT_RAM, 0, 0, 1, TGT_RAM, 32'h01ff_ffff, 0, 1);
    add_probe(WR, 32'h0200_0000, 0, 0, MT_RAM, 0, 0, 1, TGT_VETO, 32'h0, 0, 0);
    walk_probes();
    settle();

    cfg_write(CFG_PCI_ENABLE, 32'd1);
    cfg_write(CFG_SMRAM_AVAIL, 32'd1);
    cfg_write(CFG_SMRAM_OPEN, 32'd0);
    cfg_we <= 1'b0;
    add_probe(RD, 32'h000c_0000, 0, 0, MT_ROM, 0, 0, 0, TGT_VETO, 32'h0, 0, 0);
    add_probe(RD, 32'h000c_8000, 0, 0, MT_RAM, 0, 0, 1, TGT_RAM, 32'h000c_8000, 0, 0);
    add_probe(RD, 32'h000c_ffff, 0, 0, MT_BAD2, 0, 0, 1, TGT_VETO, 32'h0, 1, 0);
    add_probe(RD, 32'h000f_ffff, 0, 0, MT_BAD3, 0, 0, 1, TGT_VETO, 32'h0, 1, 0);
    add_probe(WR, 32'h000c_0000, 0, 0, MT_BAD2, 0, 0, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(WR, 32'h000a_0000, 1, 1, MT_ROM, 0, 0, 1, TGT_RAM, 32'h000a_0000, 0, 0);
    add_probe(RD, 32'h000b_ffff, 1, 0, MT_ROM, 0, 0, 1, TGT_VETO, 32'h0, 0, 0);
    add_probe(WR, 32'h000b_0000, 1, 1, MT_ROM, 1, 1, 1, TGT_RAM, 32'h000b_0000, 0, 0);
    walk_probes();

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      quiet = (ph % 3 == 2);
      case (ph % 5)
        0: ram = 32'h0000_0000;
        1: ram = 32'hffff_ffff;
        2: ram = {12'($urandom_range(1, 4095)), 20'd0};
        3: ram = 32'h0010_0000;
        default: ram = $urandom();
      endcase
      case (ph % 6)
        0: apic = 32'hfee0_0000;
        1: apic = 32'h000a_0000;
        2: apic = 32'hffff_f000;
        3: apic = 32'h0000_0000;
        4: apic = $urandom();
        default: apic = $urandom() & 32'hffff_f000;
      endcase
      // unused indexes must leave every register alone
      cfg_write(CFG_APIC_PAGE + 3'($urandom_range(1, 3)), $urandom());
      cfg_write(CFG_RAM_SIZE, ram);
      cfg_write(CFG_PCI_ENABLE, {31'($urandom()), ph[0]});
      cfg_write(CFG_SMRAM_AVAIL, {31'($urandom()), ph[1]});
      cfg_write(CFG_SMRAM_OPEN, {31'($urandom()), ph[2]});
      cfg_write(CFG_APIC_PAGE, apic);
      cfg_we <= 1'b0;
      hold_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == hold_at) settle();
        send_access(random_access(), 1'b0, '0);
      end
    end

    quiet = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("[pc_memory_map_decode_core] OK");
    end else begin
      $display("[pc_memory_map_decode_core] ERROR");
    end
    $finish;
  end
endmodule
